// File: src/dgc_pkg.sv
`timescale 1ns / 1ps
package dgc_pkg;
   localparam int CHANNELS = 512;
   localparam int CHAN_W = 9;
   localparam int ADC_W = 12;
   localparam int ADC_BITS = 12;
   localparam int CAL_W = 16;
   localparam int ENERGY_W = 24;
   localparam int MAG_W = 17;
   localparam int NUM_W = MAG_W + 10;
   localparam int DIV_STAGES = NUM_W;
   localparam logic [ADC_W-1:0] LIMIT_RESET = 12'd3800;
   localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((1 << ADC_BITS) - 1);
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_CONVERT = 1'b1;

   typedef struct packed {
      logic             action;
      logic [CHAN_W-1:0] channel;
      logic [ADC_W-1:0] adc_high;
      logic [ADC_W-1:0] adc_low;
      logic [CAL_W-1:0] pedestal_high;
      logic [CAL_W-1:0] pedestal_low;
      logic [CAL_W-1:0] scale_high;
      logic [CAL_W-1:0] scale_low;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]   cell_res;
      logic [ENERGY_W-1:0] energy;
      logic                low_gain_used;
      logic                scale_was_zero;
      logic                saturated;
   } rsp_type;

   typedef struct packed {
      logic              action;
      logic [CHAN_W-1:0] channel;
      logic [ADC_W-1:0]  adc;
      logic              low_path;
      logic              in_range;
      logic [CAL_W-1:0]  pedestal_high;
      logic [CAL_W-1:0]  pedestal_low;
      logic [CAL_W-1:0]  scale_high;
      logic [CAL_W-1:0]  scale_low;
   } cmd_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic              low_path;
      logic              zero;
      logic              negative;
      logic [NUM_W-1:0]  rem;
      logic [NUM_W-1:0]  num;
      logic [CAL_W-1:0]  scale;
      logic [NUM_W-1:0]  quo;
   } div_type;
endpackage

// File: src/dgc_if.sv
`timescale 1ns / 1ps
interface dgc_req_if;
   logic valid;
   logic ready;
   dgc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dgc_rsp_if;
   logic valid;
   logic ready;
   dgc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: src/dual_gain_adc_energy_calibrator.sv
`timescale 1ns / 1ps
// Dual-gain calorimeter energy calibrator.
// req channel: valid/ready transfer of one item. action load writes the four
// calibration entries of a channel (no response); action convert yields one
// rsp transfer with the channel, signed Q16.8 energy and status flags.
// csr_we/csr_wdata write the high-gain limit; write only while idle.
// Throughput: one item per cycle while req_ready is high. A convert passes the
// command queue, table read, operand setup, the 27-stage restoring divider
// pipeline, output register and result buffer before rsp_valid rises.
// Loads pass through the command queue in order with converts, so a convert
// sees exactly the loads transferred before it.
// Reset clears all queues and sets the limit to 3800; the tables are not
// cleared and must be loaded before use.
// When rsp_ready is low, results collect in a 32-entry result buffer; the
// back end stops taking commands once buffer plus in-flight reach 32, and the
// 4-entry command queue then fills and drops req_ready.
module dual_gain_adc_energy_calibrator (
   input  logic                        clock,
   input  logic                        reset,
   dgc_req_if.sink                     req,
   dgc_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic [dgc_pkg::ADC_W-1:0]   csr_wdata
);
   logic [dgc_pkg::ADC_W-1:0] limit_ff;
   logic cmd_valid, cmd_ready;
   dgc_pkg::cmd_type cmd_data;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= dgc_pkg::LIMIT_RESET;
      else if (csr_we) limit_ff <= csr_wdata;
   end

   dgc_front u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .limit(limit_ff),
      .cmd_valid, .cmd_ready, .cmd_data
   );

   dgc_back u_back (
      .clock, .reset,
      .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
   );

   a_zero_energy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.scale_was_zero |-> rsp.data.energy == '0 && !rsp.data.saturated)
      else $error("zero scale with nonzero energy");
   a_sat_val: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.saturated |->
         rsp.data.energy == 24'h7FFFFF || rsp.data.energy == 24'h800000)
      else $error("saturated energy not at a limit");
   a_limit: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> limit_ff == $past(csr_wdata))
      else $error("limit write lost");
endmodule

// File: src/dgc_front.sv
`timescale 1ns / 1ps
module dgc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  dgc_pkg::req_type                req_data,
   input  logic [dgc_pkg::ADC_W-1:0]       limit,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output dgc_pkg::cmd_type                cmd_data
);
   localparam int QD = 4;
   dgc_pkg::cmd_type q_ff [QD];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic push, pop;
   logic [dgc_pkg::ADC_W-1:0] ah, al;
   dgc_pkg::cmd_type c;

   assign req_ready = cnt_ff != 3'(QD);
   assign push = req_valid && req_ready;
   assign cmd_valid = cnt_ff != 3'd0;
   assign pop = cmd_valid && cmd_ready;
   assign cmd_data = q_ff[rp_ff];

   always_comb begin
      ah = req_data.adc_high & dgc_pkg::ADC_MASK;
      al = req_data.adc_low & dgc_pkg::ADC_MASK;
      c.action = req_data.action;
      c.channel = req_data.channel;
      c.low_path = ah >= limit;
      c.adc = c.low_path ? al : ah;
      c.in_range = 32'(req_data.channel) < dgc_pkg::CHANNELS;
      c.pedestal_high = req_data.pedestal_high;
      c.pedestal_low = req_data.pedestal_low;
      c.scale_high = req_data.scale_high;
      c.scale_low = req_data.scale_low;
      wp_in = push ? wp_ff + 2'd1 : wp_ff;
      rp_in = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= c;
   end
endmodule

// File: src/dgc_back.sv
`timescale 1ns / 1ps
module dgc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  dgc_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dgc_pkg::rsp_type rsp_data
);
   localparam int N = dgc_pkg::DIV_STAGES;
   logic [dgc_pkg::CAL_W-1:0] ph_mem [dgc_pkg::CHANNELS];
   logic [dgc_pkg::CAL_W-1:0] pl_mem [dgc_pkg::CHANNELS];
   logic [dgc_pkg::CAL_W-1:0] sh_mem [dgc_pkg::CHANNELS];
   logic [dgc_pkg::CAL_W-1:0] sl_mem [dgc_pkg::CHANNELS];
   logic [dgc_pkg::CAL_W-1:0] ph_ff, pl_ff, sh_ff, sl_ff;
   logic v1_ff;
   dgc_pkg::cmd_type c1_ff;
   logic v2_ff;
   dgc_pkg::div_type d2_ff;
   logic dv_ff [N];
   dgc_pkg::div_type dd_ff [N];
   dgc_pkg::div_type d2_in;
   dgc_pkg::div_type dd_in [N];
   dgc_pkg::rsp_type r_in;
   logic vo_ff;
   dgc_pkg::rsp_type ro_ff;
   localparam int FD = 32;
   dgc_pkg::rsp_type f_ff [FD];
   logic [4:0] fw_ff, fr_ff;
   logic [5:0] fc_ff, infl_ff, infl_in;
   logic issue, issue_conv, load_en, fpush, fpop;
   logic [dgc_pkg::CAL_W-1:0] ped, scl;
   logic [dgc_pkg::MAG_W-1:0] pos;

   assign cmd_ready = 6'(32'(fc_ff) + 32'(infl_ff)) < 6'(FD);
   assign issue = cmd_valid && cmd_ready;
   assign issue_conv = issue && cmd_data.action == dgc_pkg::ACT_CONVERT;
   assign load_en = issue && cmd_data.action == dgc_pkg::ACT_LOAD && cmd_data.in_range;
   assign fpush = vo_ff;
   assign rsp_valid = fc_ff != 6'd0;
   assign fpop = rsp_valid && rsp_ready;
   assign rsp_data = f_ff[fr_ff];
   assign infl_in = infl_ff + 6'(issue_conv) - 6'(fpush);

   always_ff @(posedge clock) begin
      if (load_en) begin
         ph_mem[cmd_data.channel] <= cmd_data.pedestal_high;
         pl_mem[cmd_data.channel] <= cmd_data.pedestal_low;
         sh_mem[cmd_data.channel] <= cmd_data.scale_high;
         sl_mem[cmd_data.channel] <= cmd_data.scale_low;
      end
      ph_ff <= ph_mem[cmd_data.channel];
      pl_ff <= pl_mem[cmd_data.channel];
      sh_ff <= sh_mem[cmd_data.channel];
      sl_ff <= sl_mem[cmd_data.channel];
   end

   always_comb begin
      ped = c1_ff.low_path ? pl_ff : ph_ff;
      scl = c1_ff.in_range ? (c1_ff.low_path ? sl_ff : sh_ff) : '0;
      pos = {1'b0, c1_ff.adc, 4'b0};
      d2_in.channel = c1_ff.channel;
      d2_in.low_path = c1_ff.low_path;
      d2_in.zero = scl == '0;
      d2_in.negative = {1'b0, ped} > pos;
      d2_in.num = {(d2_in.negative ? {1'b0, ped} - pos : pos - {1'b0, ped}), 10'b0}
                  + dgc_pkg::NUM_W'(scl >> 1);
      d2_in.rem = '0;
      d2_in.scale = scl;
      d2_in.quo = '0;
   end

   for (genvar i = 0; i < N; i++) begin : g_div
      dgc_pkg::div_type src;
      logic [dgc_pkg::NUM_W:0] trial;
      assign src = (i == 0) ? d2_ff : dd_ff[(i == 0) ? 0 : i-1];
      always_comb begin
         dd_in[i] = src;
         trial = {src.rem, src.num[dgc_pkg::NUM_W-1-i]}
                 - (dgc_pkg::NUM_W+1)'(src.scale);
         if (!trial[dgc_pkg::NUM_W]) begin
            dd_in[i].rem = trial[dgc_pkg::NUM_W-1:0];
            dd_in[i].quo[dgc_pkg::NUM_W-1-i] = 1'b1;
         end else begin
            dd_in[i].rem = {src.rem[dgc_pkg::NUM_W-2:0], src.num[dgc_pkg::NUM_W-1-i]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv_ff[i] <= 1'b0;
         else dv_ff[i] <= (i == 0) ? v2_ff : dv_ff[(i == 0) ? 0 : i-1];
         dd_ff[i] <= dd_in[i];
      end
   end

   always_comb begin
      dgc_pkg::div_type d;
      d = dd_ff[N-1];
      r_in.cell_res = d.channel;
      r_in.low_gain_used = d.low_path;
      r_in.scale_was_zero = d.zero;
      r_in.saturated = 1'b0;
      r_in.energy = '0;
      if (!d.zero) begin
         if (d.negative) begin
            if (d.quo > dgc_pkg::NUM_W'(24'h800000)) begin
               r_in.saturated = 1'b1;
               r_in.energy = 24'h800000;
            end else r_in.energy = 24'(-d.quo);
         end else begin
            if (d.quo > dgc_pkg::NUM_W'(24'h7FFFFF)) begin
               r_in.saturated = 1'b1;
               r_in.energy = 24'h7FFFFF;
            end else r_in.energy = d.quo[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
         fw_ff <= '0;
         fr_ff <= '0;
         fc_ff <= '0;
         infl_ff <= '0;
      end else begin
         v1_ff <= issue_conv;
         v2_ff <= v1_ff;
         vo_ff <= dv_ff[N-1];
         fw_ff <= fpush ? fw_ff + 5'd1 : fw_ff;
         fr_ff <= fpop ? fr_ff + 5'd1 : fr_ff;
         fc_ff <= fc_ff + 6'(fpush) - 6'(fpop);
         infl_ff <= infl_in;
      end
      c1_ff <= cmd_data;
      d2_ff <= d2_in;
      ro_ff <= r_in;
      if (fpush) f_ff[fw_ff] <= ro_ff;
   end
endmodule
